// ===== design/fswq_pkg.sv =====
package fswq_pkg;

  localparam int QueueDepth   = 8;
  localparam int QueueAddrW   = 3;
  localparam int SlotW        = 3;
  localparam int SlotMaskW    = 8;
  localparam int AddrW        = 32;
  localparam int WordW        = 32;
  localparam int CountW       = 4;
  localparam int MaxSlotsDef  = 8;
  localparam logic [CountW-1:0] SlotCountReset = 4'd7;
  localparam logic [WordW-1:0]  ErasedWord     = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_SUBMIT  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_COMPARE = 2'd2;

  localparam logic [7:0] JOB_INIT   = 8'd1;
  localparam logic [7:0] JOB_WRITE  = 8'd2;
  localparam logic [7:0] JOB_VERIFY = 8'd3;

  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_BUSY       = 2'd1;
  localparam logic [1:0] ST_REJECTED   = 2'd2;
  localparam logic [1:0] ST_NOT_SUBMIT = 2'd3;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_ERASE = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;

  typedef struct packed {
    logic push;
    logic pop;
    logic flags_init;
    logic flags_update;
  } dp_cmd_t;

  typedef struct packed {
    logic queue_empty;
    logic slot_ok;
    logic head_verify;
    logic match_eff;
    logic erased_eff;
  } dp_stat_t;

endpackage

// ===== design/fswq_ctrl.sv =====
module fswq_ctrl
  import fswq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [1:0] command,
  input  logic [7:0] job_code,
  input  logic       spi_busy,
  input  logic       last_word,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic [1:0] status,
  output logic [2:0] op,
  output logic       done,
  output logic       running_next
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_ERASE = 2'd2;
  localparam logic [1:0] PH_WRITE = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       running;

  always_comb begin
    status       = ST_NOT_SUBMIT;
    op           = OP_NONE;
    done         = 1'b0;
    phase_next   = phase;
    running_next = running;
    cmd          = '0;
    if (en) begin
      unique case (command)
        CMD_SUBMIT: begin
          if (spi_busy) begin
            status = ST_BUSY;
          end else if (job_code == JOB_INIT) begin
            if (running) begin
              status = ST_REJECTED;
            end else begin
              status = ST_ACCEPTED;
              op     = OP_INIT;
            end
          end else if (job_code == JOB_WRITE || job_code == JOB_VERIFY) begin
            if (stat.slot_ok) begin
              status       = ST_ACCEPTED;
              cmd.push     = 1'b1;
              running_next = 1'b1;
            end else begin
              status = ST_REJECTED;
            end
          end else begin
            status = ST_REJECTED;
          end
        end
        CMD_TICK: begin
          if (stat.queue_empty) begin
            phase_next   = PH_IDLE;
            running_next = 1'b0;
          end else begin
            running_next = 1'b1;
            unique case (phase)
              PH_IDLE: begin
                if (stat.head_verify) begin
                  op             = OP_READ;
                  phase_next     = PH_READ;
                  cmd.flags_init = 1'b1;
                end else begin
                  op         = OP_WRITE;
                  phase_next = PH_WRITE;
                end
              end
              PH_ERASE: begin
                op         = OP_WRITE;
                phase_next = PH_WRITE;
              end
              PH_WRITE: begin
                cmd.pop    = 1'b1;
                done       = 1'b1;
                phase_next = PH_IDLE;
              end
              default: begin
                // reading: the compare pairs decide the job
              end
            endcase
          end
        end
        CMD_COMPARE: begin
          if (phase == PH_READ && !stat.queue_empty) begin
            cmd.flags_update = 1'b1;
            if (last_word) begin
              cmd.flags_init = 1'b1;
              if (stat.match_eff) begin
                cmd.pop    = 1'b1;
                done       = 1'b1;
                phase_next = PH_IDLE;
              end else if (stat.erased_eff) begin
                op         = OP_WRITE;
                phase_next = PH_WRITE;
              end else begin
                op         = OP_ERASE;
                phase_next = PH_ERASE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      running <= 1'b0;
    end else begin
      phase   <= phase_next;
      running <= running_next;
    end
  end

endmodule

// ===== design/fswq_datapath.sv =====
module fswq_datapath
  import fswq_pkg::*;
#(
  parameter int MAX_SLOTS = MaxSlotsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CountW-1:0]    cfg_data,
  input  logic [7:0]           job_code,
  input  logic [SlotW-1:0]     slot_index,
  input  logic [AddrW-1:0]     flash_address,
  input  logic [WordW-1:0]     readback_word,
  input  logic [WordW-1:0]     source_word,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [AddrW-1:0]     head_address,
  output logic [SlotW-1:0]     head_slot,
  output logic [SlotMaskW-1:0] free_mask_next
);

  localparam logic [CountW-1:0] MaxSlots = CountW'(MAX_SLOTS);
  localparam logic [CountW-1:0] FullCount = CountW'(QueueDepth);

  logic [CountW-1:0]     slot_count;
  logic [SlotW-1:0]      q_slot [QueueDepth];
  logic [AddrW-1:0]      q_addr [QueueDepth];
  logic                  q_verify [QueueDepth];
  logic [QueueAddrW-1:0] head;
  logic [QueueAddrW-1:0] tail;
  logic [CountW-1:0]     count;
  logic [SlotMaskW-1:0]  slot_busy;
  logic [SlotMaskW-1:0]  slot_busy_next;
  logic                  all_erased;
  logic                  all_match;
  logic [CountW-1:0]     usable;
  logic [SlotMaskW-1:0]  usable_mask;

  assign usable = (slot_count > MaxSlots) ? MaxSlots : slot_count;

  always_comb begin
    for (int n = 0; n < SlotMaskW; n++) begin
      usable_mask[n] = (CountW'(n) < usable);
    end
  end

  assign head_slot    = q_slot[head];
  assign head_address = q_addr[head];

  assign stat.queue_empty = (count == '0);
  assign stat.head_verify = q_verify[head];
  assign stat.slot_ok     = ({1'b0, slot_index} < usable) && !slot_busy[slot_index]
                            && (count < FullCount);
  assign stat.match_eff   = all_match && (readback_word == source_word);
  assign stat.erased_eff  = all_erased && (readback_word == ErasedWord);

  always_comb begin
    slot_busy_next = slot_busy;
    if (cmd.push) begin
      slot_busy_next[slot_index] = 1'b1;
    end else if (cmd.pop) begin
      slot_busy_next[head_slot] = 1'b0;
    end
  end

  assign free_mask_next = usable_mask & ~slot_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SlotCountReset;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      slot_busy  <= '0;
      all_erased <= 1'b1;
      all_match  <= 1'b1;
    end else begin
      if (cfg_write) begin
        slot_count <= cfg_data;
      end
      slot_busy <= slot_busy_next;
      if (cmd.push) begin
        tail  <= tail + 1'b1;
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        head  <= head + 1'b1;
        count <= count - 1'b1;
      end
      priority if (cmd.flags_init) begin
        all_erased <= 1'b1;
        all_match  <= 1'b1;
      end else if (cmd.flags_update) begin
        all_erased <= stat.erased_eff;
        all_match  <= stat.match_eff;
      end
    end
  end

  // queue entries: written at the tail, no reset
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q_slot[tail]   <= slot_index;
      q_addr[tail]   <= flash_address;
      q_verify[tail] <= (job_code == JOB_VERIFY);
    end
  end

endmodule

// ===== design/flash_sector_write_queue_top.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    command, job_code, slot_index, flash_address,
//                                           spi_busy, readback_word, source_word, last_word
// out       output     out_valid/out_ready  submit_status, flash_op, op_address, op_slot,
//                                           slot_done, free_slot_mask, engine_running
// cfg       input      cfg_write            cfg_data (slot_count)
//
// Each item is decoded and its result registered in the same cycle: one item per cycle
// while the output register is empty or out_ready is high, limited by the single output register.
// Reset (rst, synchronous) empties the queue, frees all slots and sets slot_count to 7.
// A result waiting on out_ready holds in the output register; a new item is taken in
// the cycle the waiting result transfers.
module flash_sector_write_queue_top
  import fswq_pkg::*;
#(
  parameter int MAX_SLOTS = MaxSlotsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CountW-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [7:0]           job_code,
  input  logic [SlotW-1:0]     slot_index,
  input  logic [AddrW-1:0]     flash_address,
  input  logic                 spi_busy,
  input  logic [WordW-1:0]     readback_word,
  input  logic [WordW-1:0]     source_word,
  input  logic                 last_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           submit_status,
  output logic [2:0]           flash_op,
  output logic [AddrW-1:0]     op_address,
  output logic [SlotW-1:0]     op_slot,
  output logic                 slot_done,
  output logic [SlotMaskW-1:0] free_slot_mask,
  output logic                 engine_running
);

  logic                 take;
  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [1:0]           status;
  logic [2:0]           op;
  logic                 done;
  logic                 running_next;
  logic [AddrW-1:0]     head_address;
  logic [SlotW-1:0]     head_slot;
  logic [SlotMaskW-1:0] free_mask_next;
  logic                 op_on_head;

  // take the next item whenever the output register is empty or drains now
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  fswq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .en           (take),
    .command      (command),
    .job_code     (job_code),
    .spi_busy     (spi_busy),
    .last_word    (last_word),
    .stat         (stat),
    .cmd          (cmd),
    .status       (status),
    .op           (op),
    .done         (done),
    .running_next (running_next)
  );

  fswq_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .job_code       (job_code),
    .slot_index     (slot_index),
    .flash_address  (flash_address),
    .readback_word  (readback_word),
    .source_word    (source_word),
    .cmd            (cmd),
    .stat           (stat),
    .head_address   (head_address),
    .head_slot      (head_slot),
    .free_mask_next (free_mask_next)
  );

  // address and slot go out only with read, erase and write; otherwise drive zero
  assign op_on_head = (op == OP_READ) || (op == OP_ERASE) || (op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload: load on transfer in, hold while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      submit_status  <= status;
      flash_op       <= op;
      op_address     <= op_on_head ? head_address : '0;
      op_slot        <= op_on_head ? head_slot : '0;
      slot_done      <= done;
      free_slot_mask <= free_mask_next;
      engine_running <= running_next;
    end
  end

endmodule
